>>> rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define NFPF_ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define NFPF_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/nfpf_pkg.sv
`default_nettype none

package nfpf_pkg;

	localparam logic [7:0] MAX_MESSAGE_BYTES = 8'd223;
	localparam logic [7:0] SINGLE_FRAME_MAX  = 8'd8;
	localparam logic [3:0] FRAME_BYTES       = 4'd8;
	localparam logic [3:0] PDU2_NIBBLE       = 4'hF;

	// framer state carried from beat to beat
	typedef struct packed {
		logic [2:0]  seq;
		logic [63:0] buffer;
		logic [3:0]  bytes_in_frame;
		logic [4:0]  frame_index;
		logic [7:0]  bytes_remaining;
		logic [31:0] ident;
		logic [63:0] msg_time;
		logic        fast_mode;
	} nfpf_state_t;

	// one input beat
	typedef struct packed {
		logic        first_byte;
		logic [7:0]  data_byte;
		logic [7:0]  message_length;
		logic [2:0]  priority_req;
		logic [17:0] pgn;
		logic [7:0]  source_address;
		logic [7:0]  destination_address;
		logic [63:0] timestamp;
	} nfpf_item_t;

	// one finished frame
	typedef struct packed {
		logic        emit;
		logic [31:0] ident;
		logic [63:0] data;
		logic [3:0]  length;
		logic [63:0] msg_time;
		logic        last;
	} nfpf_frame_t;

	// extended identifier: prio 28..26, pgn 25..8, src 7..0, bit 31 set
	function automatic logic [31:0] build_ident(
		input logic [2:0]  prio,
		input logic [17:0] pgn,
		input logic [7:0]  src,
		input logic [7:0]  dst
	);
		logic [31:0] id;
		id = {1'b1, 2'b00, prio, pgn, src};
		if (pgn[15:12] != PDU2_NIBBLE) begin
			id[15:8] = id[15:8] | dst;
		end
		return id;
	endfunction

	// fast packet header byte: message sequence less one in 7..5, frame index in 4..0
	function automatic logic [7:0] header_byte(
		input logic [2:0] seq,
		input logic [4:0] idx
	);
		return {seq - 3'd1, idx};
	endfunction

endpackage

`default_nettype wire

>>> rtl/nfpf_step.sv
`default_nettype none

// One beat of framing: next state and the frame, if any, that the beat closes.
module nfpf_step (
	input  wire nfpf_pkg::nfpf_state_t cur,
	input  wire nfpf_pkg::nfpf_item_t  item,
	output nfpf_pkg::nfpf_state_t      nxt,
	output nfpf_pkg::nfpf_frame_t      frame
);

	nfpf_pkg::nfpf_state_t st;
	logic [7:0]            len_sat;
	logic                  last;

	always_comb begin
		st      = cur;
		frame   = '0;
		last    = 1'b0;
		len_sat = (item.message_length > nfpf_pkg::MAX_MESSAGE_BYTES) ?
			nfpf_pkg::MAX_MESSAGE_BYTES : item.message_length;

		if (item.first_byte) begin
			st.ident = nfpf_pkg::build_ident(item.priority_req, item.pgn,
				item.source_address, item.destination_address);
			st.msg_time        = item.timestamp;
			st.bytes_remaining = len_sat;
			st.buffer          = '0;
			st.bytes_in_frame  = '0;
			st.frame_index     = '0;
			st.fast_mode       = 1'b0;
			if (len_sat > nfpf_pkg::SINGLE_FRAME_MAX) begin
				st.fast_mode      = 1'b1;
				st.seq            = st.seq + 3'd1;
				st.buffer         = {48'd0, len_sat, nfpf_pkg::header_byte(st.seq, 5'd0)};
				st.bytes_in_frame = 4'd2;
			end
		end

		if (st.bytes_remaining != 8'd0) begin
			for (int k = 0; k < 8; k++) begin
				if (st.bytes_in_frame[2:0] == 3'(k)) begin
					st.buffer[8*k +: 8] = st.buffer[8*k +: 8] | item.data_byte;
				end
			end
			st.bytes_in_frame  = st.bytes_in_frame + 4'd1;
			st.bytes_remaining = st.bytes_remaining - 8'd1;
			last               = (st.bytes_remaining == 8'd0);

			if (last || (st.bytes_in_frame >= nfpf_pkg::FRAME_BYTES)) begin
				frame.emit     = 1'b1;
				frame.ident    = st.ident;
				frame.data     = st.buffer;
				frame.length   = st.bytes_in_frame;
				frame.msg_time = st.msg_time;
				frame.last     = last;
				if (last) begin
					st.buffer         = '0;
					st.bytes_in_frame = '0;
					st.frame_index    = '0;
					st.fast_mode      = 1'b0;
				end else begin
					st.frame_index = st.frame_index + 5'd1;
					if (st.fast_mode) begin
						st.buffer = {56'd0, nfpf_pkg::header_byte(st.seq, st.frame_index)};
						st.bytes_in_frame = 4'd1;
					end else begin
						st.buffer         = '0;
						st.bytes_in_frame = '0;
					end
				end
			end
		end

		nxt = st;
	end

endmodule

`default_nettype wire

>>> rtl/nmea_fast_packet_framer.sv
// A beat is registered at the input; the frame it closes, in the output register.
// One payload byte per cycle unless the output stalls; at most one frame per byte.
// in_stall rises only while the output register holds a frame that is stalled.
// Reset (arst_n low, asynchronous) clears the framer state, the sequence number
// and both valid flags; no frame is pending after reset.
`default_nettype none

module nmea_fast_packet_framer (
	input  wire logic        clk,
	input  wire logic        arst_n,

	// payload byte channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        first_byte,
	input  wire logic [7:0]  data_byte,
	input  wire logic [7:0]  message_length,
	input  wire logic [2:0]  priority_req,
	input  wire logic [17:0] pgn,
	input  wire logic [7:0]  source_address,
	input  wire logic [7:0]  destination_address,
	input  wire logic [63:0] timestamp,

	// CAN frame channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      can_identifier,
	output logic [63:0]      frame_data,
	output logic [3:0]       frame_length,
	output logic [63:0]      frame_time,
	output logic             last_frame
);

	// ------------------------------------------------------------------
	// Stage 1: input register. A beat sits here until the output register
	// can take whatever it produces.
	// ------------------------------------------------------------------
	logic                  valid_s1;
	nfpf_pkg::nfpf_item_t  item_s1;
	logic                  in_accept;
	logic                  advance;
	logic                  fire;

	// framer state and the combinational step
	nfpf_pkg::nfpf_state_t state_q;
	nfpf_pkg::nfpf_state_t state_nxt;
	nfpf_pkg::nfpf_frame_t frame;

	// output register
	logic                  out_valid_q;
	logic [31:0]           can_identifier_q;
	logic [63:0]           frame_data_q;
	logic [3:0]            frame_length_q;
	logic [63:0]           frame_time_q;
	logic                  last_frame_q;

	// Output register is free when empty or being drained this cycle.
	assign advance   = !out_valid_q || !out_stall;
	assign fire      = valid_s1 && advance;
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1.first_byte          <= first_byte;
			item_s1.data_byte           <= data_byte;
			item_s1.message_length      <= message_length;
			item_s1.priority_req        <= priority_req;
			item_s1.pgn                 <= pgn;
			item_s1.source_address      <= source_address;
			item_s1.destination_address <= destination_address;
			item_s1.timestamp           <= timestamp;
		end
	end

	// ------------------------------------------------------------------
	// Framing step: header latch, byte packing, frame close decision.
	// ------------------------------------------------------------------
	nfpf_step u_step (
		.cur   (state_q),
		.item  (item_s1),
		.nxt   (state_nxt),
		.frame (frame)
	);

	// State moves only when the stage-1 beat is consumed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (fire) begin
			state_q <= state_nxt;
		end
	end

	// ------------------------------------------------------------------
	// Output register: holds a finished frame until the sink takes it.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= frame.emit;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && frame.emit) begin
			can_identifier_q <= frame.ident;
			frame_data_q     <= frame.data;
			frame_length_q   <= frame.length;
			frame_time_q     <= frame.msg_time;
			last_frame_q     <= frame.last;
		end
	end

	assign out_valid      = out_valid_q;
	assign can_identifier = can_identifier_q;
	assign frame_data     = frame_data_q;
	assign frame_length   = frame_length_q;
	assign frame_time     = frame_time_q;
	assign last_frame     = last_frame_q;

endmodule

`default_nettype wire

>>> rtl/nfpf_checker.sv
`default_nettype none

`include "assert_macros.svh"

// Port-level checks for the framer.
module nfpf_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [31:0] can_identifier,
	input wire logic [63:0] frame_data,
	input wire logic [3:0]  frame_length,
	input wire logic        last_frame
);

	// stalled frame holds
	`NFPF_ASSERT_CLK(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(frame_data) && $stable(can_identifier), "stalled frame changed")

	// input backpressure only comes from a stalled output frame
	`NFPF_ASSERT_CLK(a_stall_cause, clk, arst_n, in_stall |-> out_valid && out_stall, "input stalled without output stall")

	// identifier carries the extended flag and nothing in bits 30..29
	`NFPF_ASSERT_CLK(a_ext_flag, clk, arst_n, out_valid |-> can_identifier[31] && (can_identifier[30:29] == 2'b00), "bad identifier flag bits")

	// length stays within one CAN frame
	`NFPF_ASSERT_CLK(a_len_range, clk, arst_n, out_valid |-> (frame_length != 4'd0) && (frame_length <= 4'd8), "frame length out of range")

	// only the final frame of a message may be short
	`NFPF_ASSERT_CLK(a_full_frames, clk, arst_n, out_valid && !last_frame |-> frame_length == 4'd8, "short frame before end")

endmodule

bind nmea_fast_packet_framer nfpf_checker u_nfpf_checker (.*);

`default_nettype wire
